// File: rtl/hrmf_pkg.sv
// Package for the heart rate measurement framer.
// Holds the transaction payload types, event and status codes, and flag bit positions.
// No dependencies.
`default_nettype none

package hrmf_pkg;

    // Input transaction payload
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] value;
        logic [7:0]  cp_offset;
        logic [7:0]  cp_length;
    } hrm_in_t;

    // Output transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } hrm_out_t;

    // Event types
    localparam logic [1:0] REQ_RR     = 2'd0;
    localparam logic [1:0] REQ_ENERGY = 2'd1;
    localparam logic [1:0] REQ_CTRL   = 2'd2;
    localparam logic [1:0] REQ_NOTIFY = 2'd3;

    // Control point status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_OPCODE = 2'd1;
    localparam logic [1:0] ST_BAD_OFFSET = 2'd2;

    localparam logic [7:0] OPCODE_RESET_ENERGY = 8'h01;

    // Configuration register indexes
    localparam logic [2:0] CFG_NOTIFY_EN   = 3'd0;
    localparam logic [2:0] CFG_ENERGY_EN   = 3'd1;
    localparam logic [2:0] CFG_RR_EN       = 3'd2;
    localparam logic [2:0] CFG_CONTACT_DET = 3'd3;
    localparam logic [2:0] CFG_CONTACT_SUP = 3'd4;

    // Flags byte bit positions
    localparam int FLAG_HR16_BIT        = 0;
    localparam int FLAG_CONTACT_DET_BIT = 1;
    localparam int FLAG_CONTACT_SUP_BIT = 2;
    localparam int FLAG_ENERGY_BIT      = 3;
    localparam int FLAG_RR_BIT          = 4;

    // Sequencer states
    typedef enum logic [3:0] {
        FS_IDLE,
        FS_CP,
        FS_FLAGS,
        FS_HR_LO,
        FS_HR_HI,
        FS_EN_LO,
        FS_EN_HI,
        FS_RR_RD,
        FS_RR_LO,
        FS_RR_HI
    } hrmf_state_t;

endpackage

`default_nettype wire

// File: rtl/heart_rate_measurement_framer.sv
// Heart rate measurement framer, top level.
// Depends on hrmf_pkg for payload types, codes and the sequencer state type.
// Assertions live in hrmf_checker, bound to this module.
`default_nettype none

// Builds heart rate measurement notification packets one byte per output
// transaction. Input transactions are events: an RR interval sample (pushed
// into a drop-oldest buffer of RR_DEPTH entries when RR is enabled), an energy
// increment (added to a wrapping 16-bit total when energy is enabled), a
// control point write (one result transaction carrying a status; a good
// reset-energy write clears the total), and a notify carrying the heart rate.
// A notify, when notifications are enabled, sends a flags byte, the heart rate
// in one byte (two, little-endian, above 255), two energy bytes if enabled,
// then as many buffered RR intervals as fit in MAX_PAYLOAD bytes; the rest
// stay buffered. RR and energy events leave the block ready for the next input.
// A control write loads its result in the FS_CP state once the output is free.
// A notify sends its bytes in order, with an RR buffer read state ahead of
// each RR interval (a registered-read memory); no input is accepted until
// the last byte of a packet or control result is loaded into the output.
// Output back-pressure stretches each byte. The byte sequencer below
// is the shared unit: one output byte register fed from one selector.
module heart_rate_measurement_framer #(
    parameter int RR_DEPTH    = 20,
    parameter int MAX_PAYLOAD = 20
) (
    input  wire                logic       aclk,
    input  wire                logic       aresetn,
    // input channel
    input  wire                logic       s_valid,
    output                     logic       s_ready,
    input  wire hrmf_pkg::hrm_in_t         s_payload,
    // result channel
    output                     logic       m_valid,
    input  wire                logic       m_ready,
    output hrmf_pkg::hrm_out_t             m_payload,
    // configuration write port
    input  wire                logic       cfg_we,
    input  wire                logic [2:0] cfg_index,
    input  wire                logic [0:0] cfg_data
);
    import hrmf_pkg::*;

    localparam int PTR_W = (RR_DEPTH > 1) ? $clog2(RR_DEPTH) : 1;
    localparam int CNT_W = $clog2(RR_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CMP_W = LEN_W + 2;

    // configuration
    logic notify_en_reg, energy_en_reg, rr_en_reg, contact_det_reg, contact_sup_reg;

    // sequencer and datapath state
    hrmf_state_t       state_reg, state_next;
    logic [15:0]       hr_reg, hr_next;
    logic [1:0]        cp_status_reg, cp_status_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [PTR_W-1:0]  rr_head_reg, rr_head_next;
    logic [CNT_W-1:0]  rr_count_reg, rr_count_next;
    logic [15:0]       energy_reg, energy_next;
    logic              m_valid_reg, m_valid_next;
    hrm_out_t          m_data_reg, m_data_next;

    // RR buffer
    logic [15:0]       rr_mem [RR_DEPTH];
    logic [15:0]       rd_data_reg;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;

    assign s_ready   = (state_reg == FS_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            notify_en_reg   <= 1'b0;
            energy_en_reg   <= 1'b1;
            rr_en_reg       <= 1'b1;
            contact_det_reg <= 1'b1;
            contact_sup_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_NOTIFY_EN:   notify_en_reg   <= cfg_data[0];
                CFG_ENERGY_EN:   energy_en_reg   <= cfg_data[0];
                CFG_RR_EN:       rr_en_reg       <= cfg_data[0];
                CFG_CONTACT_DET: contact_det_reg <= cfg_data[0];
                CFG_CONTACT_SUP: contact_sup_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // RR buffer: one write port, registered read at the head pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rr_mem[mem_waddr] <= s_payload.value;
        end
        rd_data_reg <= rr_mem[rr_head_reg];
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FS_IDLE;
            rr_head_reg  <= '0;
            rr_count_reg <= '0;
            energy_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rr_head_reg  <= rr_head_next;
            rr_count_reg <= rr_count_next;
            energy_reg   <= energy_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hr_reg        <= hr_next;
        cp_status_reg <= cp_status_next;
        len_reg       <= len_next;
        m_data_reg    <= m_data_next;
    end

    // sequencer: next state, RR buffer update and output byte selection
    always_comb begin
        logic              out_free;
        logic              emit;
        logic [7:0]        emit_byte;
        logic              emit_last;
        logic [1:0]        emit_status;
        logic [CNT_W-1:0]  cnt_after;
        logic              more_rr;
        logic [SUM_W-1:0]  tail_sum;
        logic [PTR_W-1:0]  tail_ptr;
        logic [PTR_W-1:0]  head_inc;
        logic [8:0]        cp_span;
        logic [2:0]        hdr_len;
        logic [7:0]        flags;

        state_next     = state_reg;
        hr_next        = hr_reg;
        cp_status_next = cp_status_reg;
        len_next       = len_reg;
        rr_head_next   = rr_head_reg;
        rr_count_next  = rr_count_reg;
        energy_next    = energy_reg;
        m_data_next    = m_data_reg;
        out_free       = !m_valid_reg || m_ready;
        m_valid_next   = m_valid_reg && !m_ready;
        emit           = 1'b0;
        emit_byte      = '0;
        emit_last      = 1'b0;
        emit_status    = ST_OK;
        mem_we         = 1'b0;

        head_inc = (rr_head_reg == PTR_W'(RR_DEPTH - 1)) ? '0 : rr_head_reg + 1'b1;

        tail_sum = SUM_W'(rr_head_reg) + SUM_W'(rr_count_reg);
        if (tail_sum >= SUM_W'(RR_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(RR_DEPTH);
        end
        tail_ptr = tail_sum[PTR_W-1:0];

        // one more RR pair goes out after the current byte if one is left and it fits
        cnt_after = (state_reg == FS_RR_HI) ? rr_count_reg - 1'b1 : rr_count_reg;
        more_rr   = (cnt_after != '0) &&
                    (CMP_W'(len_reg) + CMP_W'(3) <= CMP_W'(MAX_PAYLOAD));

        mem_waddr = rr_head_reg;
        if (rr_count_reg != CNT_W'(RR_DEPTH)) begin
            mem_waddr = tail_ptr;
        end

        cp_span = {1'b0, s_payload.cp_offset} + {1'b0, s_payload.cp_length};

        // header bytes ahead of the RR list: flags, heart rate, energy
        hdr_len = 3'd2 + {2'b00, |hr_reg[15:8]} + (energy_en_reg ? 3'd2 : 3'd0);

        flags = '0;
        flags[FLAG_HR16_BIT]        = |hr_reg[15:8];
        flags[FLAG_CONTACT_DET_BIT] = contact_det_reg;
        flags[FLAG_CONTACT_SUP_BIT] = contact_sup_reg;
        flags[FLAG_ENERGY_BIT]      = energy_en_reg;
        // set only if the first RR pair fits behind the header
        flags[FLAG_RR_BIT]          = (rr_count_reg != '0) &&
                                      (CMP_W'(hdr_len) + CMP_W'(2) <= CMP_W'(MAX_PAYLOAD));

        case (state_reg)
            FS_IDLE: begin
                if (s_valid) begin
                    case (s_payload.req_type)
                        REQ_RR: begin
                            if (rr_en_reg) begin
                                mem_we = 1'b1;
                                if (rr_count_reg == CNT_W'(RR_DEPTH)) begin
                                    // full: overwrite the oldest entry
                                    rr_head_next = head_inc;
                                end else begin
                                    rr_count_next = rr_count_reg + 1'b1;
                                end
                            end
                        end
                        REQ_ENERGY: begin
                            if (energy_en_reg) begin
                                energy_next = energy_reg + s_payload.value;
                            end
                        end
                        REQ_CTRL: begin
                            if (s_payload.value[7:0] != OPCODE_RESET_ENERGY) begin
                                cp_status_next = ST_BAD_OPCODE;
                            end else if (cp_span > 9'd1) begin
                                cp_status_next = ST_BAD_OFFSET;
                            end else begin
                                cp_status_next = ST_OK;
                                energy_next    = '0;
                            end
                            state_next = FS_CP;
                        end
                        REQ_NOTIFY: begin
                            if (notify_en_reg) begin
                                hr_next    = s_payload.value;
                                len_next   = '0;
                                state_next = FS_FLAGS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            FS_CP: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_last   = 1'b1;
                    emit_status = cp_status_reg;
                    state_next  = FS_IDLE;
                end
            end
            FS_FLAGS: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = flags;
                    state_next = FS_HR_LO;
                end
            end
            FS_HR_LO, FS_HR_HI: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = (state_reg == FS_HR_HI) ? hr_reg[15:8] : hr_reg[7:0];
                    if (state_reg == FS_HR_LO && |hr_reg[15:8]) begin
                        state_next = FS_HR_HI;
                    end else if (energy_en_reg) begin
                        state_next = FS_EN_LO;
                    end else if (more_rr) begin
                        state_next = FS_RR_RD;
                    end else begin
                        emit_last  = 1'b1;
                        state_next = FS_IDLE;
                    end
                end
            end
            FS_EN_LO: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = energy_reg[7:0];
                    state_next = FS_EN_HI;
                end
            end
            FS_EN_HI: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = energy_reg[15:8];
                    if (more_rr) begin
                        state_next = FS_RR_RD;
                    end else begin
                        emit_last  = 1'b1;
                        state_next = FS_IDLE;
                    end
                end
            end
            FS_RR_RD: begin
                // head entry is being read into rd_data_reg
                state_next = FS_RR_LO;
            end
            FS_RR_LO: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = rd_data_reg[7:0];
                    state_next = FS_RR_HI;
                end
            end
            FS_RR_HI: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_byte     = rd_data_reg[15:8];
                    rr_head_next  = head_inc;
                    rr_count_next = cnt_after;
                    if (more_rr) begin
                        state_next = FS_RR_RD;
                    end else begin
                        emit_last  = 1'b1;
                        state_next = FS_IDLE;
                    end
                end
            end
            default: begin
                state_next = FS_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = emit_byte;
            m_data_next.last     = emit_last;
            m_data_next.status   = emit_status;
            len_next             = len_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hrmf_checker.sv
// Port-level assertions for the heart rate measurement framer.
// Depends on hrmf_pkg; bound to heart_rate_measurement_framer below.
`default_nettype none

module hrmf_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire hrmf_pkg::hrm_in_t  s_payload,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire hrmf_pkg::hrm_out_t m_payload,
    input wire logic               cfg_we,
    input wire logic [2:0]         cfg_index,
    input wire logic [0:0]         cfg_data
);
    import hrmf_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result transaction changed while stalled");

    // error status only on a lone control result: last set, zero byte
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != ST_OK |->
            m_payload.last && m_payload.out_byte == 8'h00)
        else $error("error status on a packet byte");

    // the block is busy once a control write has been accepted
    a_ctrl_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.req_type == REQ_CTRL |=> !s_ready)
        else $error("input accepted during control write");

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // the user writes configuration only while idle; not enforced
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && cfg_index == CFG_NOTIFY_EN |-> s_ready || cfg_data == $past(cfg_data))
        else $error("notify enable written while busy");

endmodule

bind heart_rate_measurement_framer hrmf_checker u_hrmf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

`default_nettype wire
